// File: rtl/core/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types and control-field codes shared by the packed string compare block.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

	// element count per operand in byte mode, and the bits of a length
	localparam int unsigned NumElem = 16;
	localparam int unsigned LenW    = 5;

	typedef logic [15:0]              elem_t;
	typedef elem_t [NumElem-1:0]      elem_vec_t;
	typedef logic [LenW-1:0]          len_t;
	typedef logic [1:0]               agg_t;
	typedef logic [1:0]               pol_t;
	typedef logic [NumElem-1:0]       mask_t;
	typedef mask_t [NumElem-1:0]      cmp_mat_t;

	// aggregation codes, ctrl bits 3:2
	localparam agg_t AGG_EQ_ANY  = 2'b00;
	localparam agg_t AGG_RANGES  = 2'b01;
	localparam agg_t AGG_EQ_EACH = 2'b10;
	localparam agg_t AGG_EQ_ORD  = 2'b11;

	// polarity codes, ctrl bits 5:4
	localparam pol_t POL_POS      = 2'b00;
	localparam pol_t POL_NEG      = 2'b01;
	localparam pol_t POL_POS_ALT  = 2'b10;
	localparam pol_t POL_MASK_NEG = 2'b11;

	// element counts as lengths
	localparam len_t LEN_BYTES = 5'd16;
	localparam len_t LEN_WORDS = 5'd8;

	// raw element k of a 128-bit operand, zero-extended to 16 bits
	function automatic elem_t get_elem(logic [127:0] v, int unsigned k, logic word);
		elem_t e;
		e = 16'h0000;
		if (word) begin
			if (k < NumElem / 2)
				e = v[16*k +: 16];
		end else begin
			e = {8'h00, v[8*k +: 8]};
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/packed_string_compare.sv
// ----------------------------------------------------------------------------
// packed_string_compare
// Throughput: one word per cycle while the output is not stalled; stages are
// element decode and length, 16x16 comparator matrix, aggregation and
// polarity, flag and output register. A stalled output holds the last stage;
// empty stages upstream still fill. Reset clears the stage valid bits only;
// payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_string_compare
	import psc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cmd,
	input  wire logic [7:0]         ctrl,
	input  wire logic [63:0]        src_lo,
	input  wire logic [63:0]        src_hi,
	input  wire logic [63:0]        set_lo,
	input  wire logic [63:0]        set_hi,
	input  wire logic signed [31:0] src_len,
	input  wire logic signed [31:0] set_len,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             match_mask,
	output logic                    carry_flag,
	output logic                    zero_flag,
	output logic                    sign_flag,
	output logic                    overflow_flag,
	output logic                    aux_flag,
	output logic                    parity_flag
);

	// stage advance chain, a bubble lets the stages above it move
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: element split, sign bias, lengths
	// ------------------------------------------------------------------
	logic       word_in, sgn_in;
	len_t       n_in;
	logic [127:0] src_in, set_in;
	elem_vec_t  src_raw, set_raw, src_el, set_el;
	len_t       src_zlen, set_zlen, src_elen, set_elen;
	logic [31:0] src_mag, set_mag;

	assign word_in = ctrl[0];
	assign sgn_in  = ctrl[1];
	assign n_in    = word_in ? LEN_WORDS : LEN_BYTES;
	assign src_in  = {src_hi, src_lo};
	assign set_in  = {set_hi, set_lo};

	// split into elements, bias the sign bit for ordered compares
	always_comb begin
		for (int k = 0; k < NumElem; k++) begin
			src_raw[k] = get_elem(src_in, k, word_in);
			set_raw[k] = get_elem(set_in, k, word_in);
			src_el[k]  = src_raw[k];
			set_el[k]  = set_raw[k];
			if (sgn_in) begin
				if (word_in) begin
					src_el[k][15] = ~src_raw[k][15];
					set_el[k][15] = ~set_raw[k][15];
				end else begin
					src_el[k][7] = ~src_raw[k][7];
					set_el[k][7] = ~set_raw[k][7];
				end
			end
		end
	end

	// implicit length: first zero element, element count when none
	always_comb begin
		src_zlen = n_in;
		set_zlen = n_in;
		for (int k = NumElem - 1; k >= 0; k--) begin
			if (len_t'(k) < n_in && src_raw[k] == 16'h0000) src_zlen = len_t'(k);
			if (len_t'(k) < n_in && set_raw[k] == 16'h0000) set_zlen = len_t'(k);
		end
	end

	// explicit length: magnitude, then clamp to element count
	assign src_mag  = src_len[31] ? (~src_len + 32'd1) : src_len;
	assign set_mag  = set_len[31] ? (~set_len + 32'd1) : set_len;
	assign src_elen = (src_mag > {27'd0, n_in}) ? n_in : src_mag[LenW-1:0];
	assign set_elen = (set_mag > {27'd0, n_in}) ? n_in : set_mag[LenW-1:0];

	elem_vec_t src_el_s1, set_el_s1;
	len_t      lsrc_s1, lset_s1;
	logic      word_s1;
	agg_t      agg_s1;
	pol_t      pol_s1;

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			src_el_s1 <= src_el;
			set_el_s1 <= set_el;
			lsrc_s1   <= cmd ? src_zlen : src_elen;
			lset_s1   <= cmd ? set_zlen : set_elen;
			word_s1   <= word_in;
			agg_s1    <= ctrl[3:2];
			pol_s1    <= ctrl[5:4];
		end
	end

	// ------------------------------------------------------------------
	// stage 2: comparator matrix with invalid-element overrides
	// ------------------------------------------------------------------
	cmp_mat_t cmp_d;
	len_t     n_s1;

	assign n_s1 = word_s1 ? LEN_WORDS : LEN_BYTES;

	// row j is the second operand element, column i the first
	always_comb begin
		for (int j = 0; j < NumElem; j++) begin
			for (int i = 0; i < NumElem; i++) begin
				logic vsrc, vset, hit;
				vsrc = len_t'(j) < lsrc_s1;
				vset = len_t'(i) < lset_s1;
				if (agg_s1 == AGG_RANGES) begin
					if (i % 2 == 1) hit = set_el_s1[i] >= src_el_s1[j];
					else            hit = set_el_s1[i] <= src_el_s1[j];
				end else begin
					hit = set_el_s1[i] == src_el_s1[j];
				end
				if (!vset && !vsrc)
					cmp_d[j][i] = (agg_s1 == AGG_EQ_EACH) || (agg_s1 == AGG_EQ_ORD);
				else if (!vset)
					cmp_d[j][i] = (agg_s1 == AGG_EQ_ORD);
				else if (!vsrc)
					cmp_d[j][i] = 1'b0;
				else
					cmp_d[j][i] = hit;
			end
		end
	end

	cmp_mat_t cmp_s2;
	len_t     lsrc_s2;
	logic     word_s2, zf_s2, sf_s2, full_s2;
	agg_t     agg_s2;
	pol_t     pol_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			cmp_s2  <= cmp_d;
			lsrc_s2 <= lsrc_s1;
			word_s2 <= word_s1;
			zf_s2   <= lsrc_s1 < n_s1;
			sf_s2   <= lset_s1 < n_s1;
			full_s2 <= lsrc_s1 == n_s1;
			agg_s2  <= agg_s1;
			pol_s2  <= pol_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: aggregation and polarity
	// ------------------------------------------------------------------
	len_t  n_s2;
	mask_t full_mask, len_mask, agg_res, pol_res;

	assign n_s2 = word_s2 ? LEN_WORDS : LEN_BYTES;

	always_comb begin
		for (int k = 0; k < NumElem; k++) begin
			full_mask[k] = len_t'(k) < n_s2;
			len_mask[k]  = len_t'(k) < lsrc_s2;
		end
	end

	always_comb begin
		for (int j = 0; j < NumElem; j++) begin
			logic any_b, rng_b, ord_b;
			any_b = 1'b0;
			rng_b = 1'b0;
			ord_b = 1'b1;
			for (int i = 0; i < NumElem; i++) begin
				if (full_mask[i]) any_b = any_b | cmp_s2[j][i];
				if (i % 2 == 0 && full_mask[i])
					rng_b = rng_b | (cmp_s2[j][i] & cmp_s2[j][i+1]);
				if (i + j < NumElem && full_mask[i+j])
					ord_b = ord_b & cmp_s2[i+j][i];
			end
			unique case (agg_s2)
				AGG_EQ_ANY:  agg_res[j] = full_mask[j] & any_b;
				AGG_RANGES:  agg_res[j] = full_mask[j] & rng_b;
				AGG_EQ_EACH: agg_res[j] = full_mask[j] & cmp_s2[j][j];
				AGG_EQ_ORD:  agg_res[j] = full_mask[j] & ord_b;
			endcase
		end
	end

	always_comb begin
		unique case (pol_s2)
			POL_POS, POL_POS_ALT: pol_res = agg_res;
			POL_NEG:              pol_res = agg_res ^ full_mask;
			POL_MASK_NEG:         pol_res = agg_res ^ len_mask;
		endcase
	end

	mask_t res_s3;
	logic  zf_s3, sf_s3, full_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			res_s3  <= pol_res;
			zf_s3   <= zf_s2;
			sf_s3   <= sf_s2;
			full_s3 <= full_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: flags and output word
	// ------------------------------------------------------------------
	mask_t res_s4;
	logic  cf_s4, zf_s4, sf_s4, af_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			res_s4 <= res_s3;
			cf_s4  <= res_s3 != '0;
			zf_s4  <= zf_s3;
			sf_s4  <= sf_s3;
			af_s4  <= (res_s3 == '0) && full_s3;
		end
	end

	assign out_valid     = v_s4;
	assign match_mask    = res_s4;
	assign carry_flag    = cf_s4;
	assign zero_flag     = zf_s4;
	assign sign_flag     = sf_s4;
	assign overflow_flag = res_s4[0];
	assign aux_flag      = af_s4;
	assign parity_flag   = 1'b0;

endmodule

`default_nettype wire
